FILE: rtl/aabb_collision_resolver_defines.svh
// Assertion macros shared by the checker of the AABB collision resolver.
// Depends on nothing; include once through the guard below.
`ifndef AABB_COLLISION_RESOLVER_DEFINES_SVH
`define AABB_COLLISION_RESOLVER_DEFINES_SVH
`define ACR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aabb check failed");
`define ACR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aabb check failed");
`endif

FILE: rtl/aabb_pkg.sv
// Types and constants for the AABB collision resolver.
// Depends on nothing.
package aabb_pkg;
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;
    localparam logic [1:0] ACT_NOP    = 2'd3;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOTFND  = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;
    localparam int         IN_W       = 200;
    localparam int         OUT_W      = 120;
    localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] POS_MIN = -24'sh800000;

    typedef struct packed {
        logic [15:0]        tag;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [22:0]        sx;
        logic [22:0]        sy;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic               fixed;
        logic [3:0]         layer;
        logic [15:0]        mask;
    } box_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        handle;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic               hit;
        logic               last;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch the incoming word
        logic add;
        logic rem_step; // shift slot idx_b into slot idx_a
        logic integ;    // integrate slot idx_a
        logic pair;     // resolve pair idx_a, idx_b
        logic emit;     // present slot idx_a
        logic reply;    // present single reply
    } cmd_t;

    typedef struct packed {
        logic found;
    } stat_t;

    function automatic logic signed [23:0] sat24(input logic signed [49:0] v);
        if (v > 50'sd8388607) return POS_MAX;
        else if (v < -50'sd8388608) return POS_MIN;
        else return v[23:0];
    endfunction

    function automatic logic signed [23:0] round_unit(input logic signed [23:0] v);
        logic signed [25:0] w;
        logic [25:0] m;
        if (v >= 0)
        begin
            w = 26'(v) + 26'sd128;
            w[7:0] = 8'd0;
        end
        else
        begin
            m = 26'(-26'(v)) + 26'd128;
            m[7:0] = 8'd0;
            w = -$signed(m);
        end
        return sat24(50'(w));
    endfunction
endpackage

FILE: rtl/aabb_datapath.sv
// Box table and arithmetic for the AABB collision resolver.
// Depends on aabb_pkg.
module aabb_datapath #(
    parameter int MAX_BOXES = 16,
    parameter int IW = 4,
    parameter int CW = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  aabb_pkg::cmd_t           cmd,
    input  logic [IW-1:0]            idx_a,
    input  logic [IW-1:0]            idx_b,
    input  logic [CW-1:0]            count,
    input  logic [1:0]               reply_status,
    input  logic [aabb_pkg::IN_W-1:0] in_word,
    output aabb_pkg::stat_t          stat,
    output aabb_pkg::result_t        result
);
    aabb_pkg::box_t box_reg [MAX_BOXES];
    logic [MAX_BOXES-1:0] hit_reg;
    logic [15:0] tag_reg;
    logic [15:0] dt_reg;
    aabb_pkg::box_t nb;
    aabb_pkg::box_t a, b, m;
    logic signed [40:0] px_p, py_p;
    logic signed [25:0] amaxx, amaxy, bmaxx, bmaxy, minx, maxx, miny, maxy, ox, oy;
    logic match, ovl, use_b;

    assign nb = '{tag: in_word[17:2], px: in_word[41:18], py: in_word[65:42],
                  sx: in_word[88:66], sy: in_word[111:89], vx: in_word[135:112],
                  vy: in_word[159:136], fixed: in_word[160], layer: in_word[164:161],
                  mask: in_word[180:165]};
    assign a = box_reg[idx_a];
    assign b = box_reg[idx_b];
    assign stat.found = (box_reg[idx_a].tag == tag_reg);

    function automatic logic signed [23:0] integ(input logic signed [23:0] p,
                                                  input logic signed [40:0] prod);
        logic [40:0] mag;
        logic signed [41:0] q;
        if (prod >= 0)
        begin
            mag = 41'(prod) + 41'd2048;
            q = 42'(mag >> 12);
        end
        else
        begin
            mag = 41'(-prod) + 41'd2048;
            q = -$signed(42'(mag >> 12));
        end
        return aabb_pkg::sat24(50'(p) + 50'(q));
    endfunction

    always_comb
    begin
        px_p = $signed(a.vx) * $signed({1'b0, dt_reg});
        py_p = $signed(a.vy) * $signed({1'b0, dt_reg});
        match = a.mask[b.layer] | b.mask[a.layer];
        amaxx = 26'(a.px) + 26'(a.sx);
        amaxy = 26'(a.py) + 26'(a.sy);
        bmaxx = 26'(b.px) + 26'(b.sx);
        bmaxy = 26'(b.py) + 26'(b.sy);
        ovl = (26'(a.px) < bmaxx) && (amaxx > 26'(b.px)) &&
              (26'(a.py) < bmaxy) && (amaxy > 26'(b.py));
        minx = (amaxx < bmaxx) ? amaxx : bmaxx;
        maxx = (a.px > b.px) ? 26'(a.px) : 26'(b.px);
        miny = (amaxy < bmaxy) ? amaxy : bmaxy;
        maxy = (a.py > b.py) ? 26'(a.py) : 26'(b.py);
        ox = minx - maxx;
        oy = miny - maxy;
        use_b = a.fixed;
        m = use_b ? b : a;
        if (ox < oy)
        begin
            if (m.vx > 0) m.px = aabb_pkg::sat24(50'(m.px) - 50'(ox));
            else if (m.vx < 0) m.px = aabb_pkg::sat24(50'(m.px) + 50'(ox));
            m.vx = '0;
            m.px = aabb_pkg::round_unit(m.px);
        end
        else if (oy > 0)
        begin
            if (m.vy > 0) m.py = aabb_pkg::sat24(50'(m.py) - 50'(oy));
            else if (m.vy < 0) m.py = aabb_pkg::sat24(50'(m.py) + 50'(oy));
            m.vy = '0;
            m.py = aabb_pkg::round_unit(m.py);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tag_reg <= (in_word[1:0] == aabb_pkg::ACT_TICK) ? 16'd0 : in_word[17:2];
            dt_reg  <= in_word[196:181];
        end
        if (cmd.add)
            box_reg[count[IW-1:0]] <= nb;
        if (cmd.rem_step && idx_a != idx_b)
            box_reg[idx_a] <= b;
        if (cmd.integ && !a.fixed)
        begin
            box_reg[idx_a].px <= integ(a.px, px_p);
            box_reg[idx_a].py <= integ(a.py, py_p);
        end
        if (cmd.pair && match && ovl && !(a.fixed && b.fixed))
        begin
            if (use_b) box_reg[idx_b] <= m;
            else box_reg[idx_a] <= m;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= '0;
        end
        else if (cmd.load)
        begin
            hit_reg <= '0;
        end
        else if (cmd.pair && match && ovl)
        begin
            hit_reg[idx_a] <= 1'b1;
            hit_reg[idx_b] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            result <= '{status: aabb_pkg::ST_OK, handle: a.tag, px: a.px, py: a.py,
                        vx: a.vx, vy: a.vy, hit: hit_reg[idx_a],
                        last: (CW'(idx_a) + CW'(1) == count)};
        else if (cmd.reply)
            result <= '{status: reply_status, handle: tag_reg,
                        px: '0, py: '0, vx: '0, vy: '0, hit: 1'b0, last: 1'b1};
    end
endmodule

FILE: rtl/aabb_ctrl.sv
// Sequencer for the AABB collision resolver: handshake, table count, loops.
// Depends on aabb_pkg.
module aabb_ctrl #(
    parameter int MAX_BOXES = 16,
    parameter int IW = 4,
    parameter int CW = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          action,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  aabb_pkg::stat_t     stat,
    output aabb_pkg::cmd_t      cmd,
    output logic [IW-1:0]       idx_a,
    output logic [IW-1:0]       idx_b,
    output logic [CW-1:0]       count,
    output logic [1:0]          reply_status
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIND  = 7'b0000010,
        S_SHIFT = 7'b0000100,
        S_INTEG = 7'b0001000,
        S_PAIR  = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] a_reg, a_next, b_reg, b_next, cnt_reg, cnt_next;
    logic [1:0] st_reg, st_next;
    logic ov_reg, ov_next;
    logic accept;

    assign s_tready = (state_reg == S_IDLE) && !ov_reg;
    assign accept = s_tvalid && s_tready;
    assign m_tvalid = ov_reg;
    assign idx_a = a_reg[IW-1:0];
    assign idx_b = b_reg[IW-1:0];
    assign count = cnt_reg;
    assign reply_status = st_reg;

    always_comb
    begin
        state_next = state_reg;
        a_next = a_reg;
        b_next = b_reg;
        cnt_next = cnt_reg;
        st_next = st_reg;
        ov_next = ov_reg && !m_tready;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    a_next = '0;
                    priority if (action == aabb_pkg::ACT_ADD)
                    begin
                        if (cnt_reg >= CW'(MAX_BOXES)) st_next = aabb_pkg::ST_FULL;
                        else
                        begin
                            st_next = aabb_pkg::ST_OK;
                            cmd.add = 1'b1;
                            cnt_next = cnt_reg + CW'(1);
                        end
                        state_next = S_OUT;
                    end
                    else if (action == aabb_pkg::ACT_REMOVE)
                    begin
                        st_next = aabb_pkg::ST_EMPTY;
                        state_next = (cnt_reg == '0) ? S_OUT : S_FIND;
                    end
                    else if (action == aabb_pkg::ACT_TICK)
                    begin
                        st_next = aabb_pkg::ST_EMPTY;
                        state_next = (cnt_reg == '0) ? S_OUT : S_INTEG;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FIND:
            begin
                if (stat.found)
                begin
                    b_next = a_reg + CW'(1);
                    state_next = S_SHIFT;
                end
                else if (a_reg + CW'(1) == cnt_reg)
                begin
                    st_next = aabb_pkg::ST_NOTFND;
                    state_next = S_OUT;
                end
                else
                    a_next = a_reg + CW'(1);
            end
            S_SHIFT:
            begin
                if (b_reg == cnt_reg)
                begin
                    cnt_next = cnt_reg - CW'(1);
                    st_next = aabb_pkg::ST_OK;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.rem_step = 1'b1;
                    a_next = b_reg;
                    b_next = b_reg + CW'(1);
                end
            end
            S_INTEG:
            begin
                cmd.integ = 1'b1;
                if (a_reg + CW'(1) == cnt_reg)
                begin
                    a_next = '0;
                    b_next = CW'(1);
                    state_next = (cnt_reg == CW'(1)) ? S_EMIT : S_PAIR;
                end
                else
                    a_next = a_reg + CW'(1);
            end
            S_PAIR:
            begin
                cmd.pair = 1'b1;
                if (b_reg + CW'(1) < cnt_reg)
                    b_next = b_reg + CW'(1);
                else if (a_reg + CW'(2) < cnt_reg)
                begin
                    a_next = a_reg + CW'(1);
                    b_next = a_reg + CW'(2);
                end
                else
                begin
                    a_next = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || m_tready)
                begin
                    cmd.emit = 1'b1;
                    ov_next = 1'b1;
                    if (a_reg + CW'(1) == cnt_reg) state_next = S_IDLE;
                    else a_next = a_reg + CW'(1);
                end
            end
            S_OUT:
            begin
                if (!ov_reg || m_tready)
                begin
                    cmd.reply = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            a_reg <= '0;
            b_reg <= '0;
            cnt_reg <= '0;
            st_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            a_reg <= a_next;
            b_reg <= b_next;
            cnt_reg <= cnt_next;
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end
endmodule

FILE: rtl/aabb_collision_resolver.sv
// AABB collision resolver: top level joining the sequencer and the box datapath.
// Depends on aabb_pkg, aabb_ctrl, aabb_datapath.
//
// Slave channel takes one command word (add, remove, tick, nop); master channel
// returns result words, tlast on the final one of each command; a nop returns none.
// Add, remove on an empty table and empty tick: the single result word is
// registered in S_OUT, after the command is accepted in S_IDLE.
// Remove with N boxes: search (S_FIND), then shift of the later boxes (S_SHIFT)
// when the handle is found, search alone when it is not, then one result word.
// Tick with N boxes: integration of each box (one box per cycle through the
// shared multipliers), a check of every pair (one pair per cycle), then N result
// words, one per cycle while the receiver is ready.
// A new command is taken only once all results of the previous one are sent.
// Reset empties the table and drops any pending result; box contents are left as
// they are and are only read once rewritten.
// A stalled receiver holds the output register and the sequencer waits.
module aabb_collision_resolver #(
    parameter int MAX_BOXES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action, handle, pos_x, pos_y, size_x, size_y, vel_x, vel_y, is_static,
    // layer, collision_mask, delta_time, zero pad
    input  logic [199:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, out_handle, out_pos_x, out_pos_y, out_vel_x, out_vel_y, collided, pad
    output logic [119:0] m_tdata,
    output logic         m_tlast
);
    localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);

    aabb_pkg::cmd_t    cmd;
    aabb_pkg::stat_t   stat;
    aabb_pkg::result_t res;
    logic [IW-1:0] idx_a, idx_b;
    logic [CW-1:0] count;
    logic [1:0] reply_status;

    aabb_ctrl #(.MAX_BOXES(MAX_BOXES), .IW(IW), .CW(CW)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .action(s_tdata[1:0]), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .stat(stat), .cmd(cmd), .idx_a(idx_a), .idx_b(idx_b), .count(count),
        .reply_status(reply_status)
    );

    aabb_datapath #(.MAX_BOXES(MAX_BOXES), .IW(IW), .CW(CW)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .idx_a(idx_a), .idx_b(idx_b),
        .count(count), .reply_status(reply_status), .in_word(s_tdata),
        .stat(stat), .result(res)
    );

    assign m_tdata = {5'd0, res.hit, res.vy, res.vx, res.py, res.px, res.handle,
                      res.status};
    assign m_tlast = res.last;
endmodule

FILE: rtl/aabb_checker.sv
// Port-level checker for the AABB collision resolver, bound to the top level.
// Depends on aabb_collision_resolver_defines.svh and aabb_pkg.
`include "aabb_collision_resolver_defines.svh"
module aabb_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata,
    input logic         m_tlast
);
    `ACR_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ACR_ASSERT_IMPL(a_busy, m_tvalid, !s_tready)
    `ACR_ASSERT_IMPL(a_err_last, m_tvalid && m_tdata[1:0] != aabb_pkg::ST_OK, m_tlast)
endmodule

bind aabb_collision_resolver aabb_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
